>>> rtl/voxel_slab_color_expander_defines.svh
// Assertion macros for the voxel slab color expander
`ifndef VOXEL_SLAB_COLOR_EXPANDER_DEFINES_SVH
`define VOXEL_SLAB_COLOR_EXPANDER_DEFINES_SVH

// same-cycle implication
`define VSCX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VSCX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/vscx_pkg.sv
// Types, constants and helpers shared by the voxel slab color expander
`timescale 1ns / 1ps
package vscx_pkg;

   localparam int PALETTE_DEPTH_DEF    = 256;
   localparam int BLOCK_COUNT_BITS_DEF = 20;

   localparam int BLOCK_BYTES_W = 20;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 20;
   localparam int RGB_W         = 24;
   localparam int WORD_W        = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_BYTES    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPAND_SIX_BIT = 1'b1;

   localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

   localparam logic OP_SLAB_BYTE = 1'b0;
   localparam logic OP_PAL_WRITE = 1'b1;

   typedef enum logic [1:0] {
      KIND_TOP    = 2'd0,
      KIND_LENGTH = 2'd1,
      KIND_FACE   = 2'd2,
      KIND_COLOUR = 2'd3
   } byte_kind_type;

   typedef enum logic [3:0] {
      PH_TOP    = 4'b0001,
      PH_LENGTH = 4'b0010,
      PH_FACE   = 4'b0100,
      PH_COLOUR = 4'b1000
   } slab_phase_type;

   function automatic logic [7:0] widen(input logic [7:0] c, input logic six);
      logic [7:0] r;
      if (six) begin
         r = {c[5:0], c[5:4]};
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

>>> rtl/vscx_channels.sv
// Valid/ready channel interfaces for slab bytes, result words and register writes
`timescale 1ns / 1ps

interface vscx_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;
   logic       first_of_block;
   logic [7:0] pal_index;
   logic [7:0] pal_red;
   logic [7:0] pal_green;
   logic [7:0] pal_blue;
   modport source (output valid, op, data_byte, first_of_block, pal_index,
                   pal_red, pal_green, pal_blue, input ready);
   modport sink   (input valid, op, data_byte, first_of_block, pal_index,
                   pal_red, pal_green, pal_blue, output ready);
endinterface

interface vscx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_word;
   logic [1:0]  byte_kind;
   logic        slab_error;
   logic        last_of_block;
   modport source (output valid, out_word, byte_kind, slab_error, last_of_block,
                   input ready);
   modport sink   (input valid, out_word, byte_kind, slab_error, last_of_block,
                   output ready);
endinterface

interface vscx_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [19:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

>>> rtl/voxel_slab_color_expander.sv
// Voxel slab color expander: slab bytes in, header and ARGB color words out
// A word goes from the table read and s1 stage through the output register to rsp_ch.
// Throughput: one byte or palette write per cycle unless rsp_ch stalls; a slab byte does one
// read and a palette write at most one write of the single-port synchronous table, never both.
// Reset clears the counters, phase, error flag and output valid and loads the
// register defaults; the palette table is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`include "voxel_slab_color_expander_defines.svh"

module voxel_slab_color_expander
   import vscx_pkg::*;
#(
   parameter int PALETTE_DEPTH    = PALETTE_DEPTH_DEF,
   parameter int BLOCK_COUNT_BITS = BLOCK_COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   vscx_req_if.sink   req_ch,
   vscx_rsp_if.source rsp_ch,
   vscx_csr_if.sink   csr_ch
);

   localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CMP_W = BLOCK_COUNT_BITS + 1;

   // configuration
   logic [BLOCK_BYTES_W-1:0] block_bytes_ff;
   logic                     expand_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= '0;
         expand_ff      <= 1'b1;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_BLOCK_BYTES:    block_bytes_ff <= csr_ch.wdata[BLOCK_BYTES_W-1:0];
            CSR_EXPAND_SIX_BIT: expand_ff      <= csr_ch.wdata[0];
            default: ;
         endcase
      end
   end

   // slab state
   logic [BLOCK_COUNT_BITS-1:0] bytes_left_ff, bytes_left_in;
   slab_phase_type              phase_ff, phase_in;
   logic [7:0]                  colours_left_ff, colours_left_in;
   logic                        failed_ff, failed_in;

   // result stage (after table read)
   logic          s1_valid_ff, s1_valid_in;
   byte_kind_type s1_kind_ff, s1_kind_in;
   logic          s1_err_ff, s1_err_in;
   logic          s1_last_ff, s1_last_in;
   logic [7:0]    s1_byte_ff;
   logic          s1_oob_ff;

   // output register
   logic          out_valid_ff;
   logic [31:0]   out_word_ff;
   byte_kind_type out_kind_ff;
   logic          out_err_ff;
   logic          out_last_ff;

   logic s1_adv;
   logic fire;
   logic idx_ok;

   assign s1_adv       = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign fire         = req_ch.valid && req_ch.ready;
   assign idx_ok       = {1'b0, req_ch.pal_index} < 9'(PALETTE_DEPTH);

   // palette table
   logic [RGB_W-1:0] palette_mem [PALETTE_DEPTH];
   logic [RGB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         if (req_ch.op == OP_PAL_WRITE) begin
            if (idx_ok) begin
               palette_mem[req_ch.pal_index[IDX_W-1:0]] <=
                  {req_ch.pal_red, req_ch.pal_green, req_ch.pal_blue};
            end
         end else begin
            rd_data_ff <= palette_mem[req_ch.data_byte[IDX_W-1:0]];
         end
      end
   end

   logic [BLOCK_COUNT_BITS-1:0] bl;
   slab_phase_type              ph;
   logic [7:0]                  cl;
   logic                        fl;
   logic [7:0]                  cl_dec;

   always_comb begin
      bl = bytes_left_ff;
      ph = phase_ff;
      cl = colours_left_ff;
      fl = failed_ff;
      if (req_ch.first_of_block) begin
         bl = BLOCK_COUNT_BITS'(block_bytes_ff);
         ph = PH_TOP;
         cl = '0;
         fl = 1'b0;
      end
      cl_dec = cl - 8'd1;

      bytes_left_in   = bl;
      phase_in        = ph;
      colours_left_in = cl;
      failed_in       = fl;
      s1_valid_in     = 1'b0;
      s1_kind_in      = KIND_TOP;
      s1_err_in       = 1'b0;
      s1_last_in      = 1'b0;

      if (!fl && bl != '0) begin
         bytes_left_in = bl - BLOCK_COUNT_BITS'(1);
         unique case (ph)
            PH_TOP: begin
               if (bl >= BLOCK_COUNT_BITS'(3)) begin
                  s1_valid_in = 1'b1;
                  s1_kind_in  = KIND_TOP;
                  phase_in    = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               s1_valid_in = 1'b1;
               s1_kind_in  = KIND_LENGTH;
               if (CMP_W'(req_ch.data_byte) + CMP_W'(2) > CMP_W'(bl)) begin
                  s1_err_in       = 1'b1;
                  s1_last_in      = 1'b1;
                  failed_in       = 1'b1;
                  phase_in        = PH_TOP;
                  colours_left_in = '0;
               end else begin
                  colours_left_in = req_ch.data_byte;
                  phase_in        = PH_FACE;
               end
            end
            PH_FACE: begin
               s1_valid_in = 1'b1;
               s1_kind_in  = KIND_FACE;
               if (cl == '0) begin
                  phase_in   = PH_TOP;
                  s1_last_in = (bl <= BLOCK_COUNT_BITS'(3));
               end else begin
                  phase_in = PH_COLOUR;
               end
            end
            PH_COLOUR: begin
               s1_valid_in     = 1'b1;
               s1_kind_in      = KIND_COLOUR;
               colours_left_in = cl_dec;
               if (cl_dec == '0) begin
                  phase_in   = PH_TOP;
                  s1_last_in = (bl <= BLOCK_COUNT_BITS'(3));
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff   <= '0;
         phase_ff        <= PH_TOP;
         colours_left_ff <= '0;
         failed_ff       <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         if (fire && req_ch.op == OP_SLAB_BYTE) begin
            bytes_left_ff   <= bytes_left_in;
            phase_ff        <= phase_in;
            colours_left_ff <= colours_left_in;
            failed_ff       <= failed_in;
         end
         if (fire) begin
            s1_valid_ff <= s1_valid_in && (req_ch.op == OP_SLAB_BYTE);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_kind_ff <= s1_kind_in;
         s1_err_ff  <= s1_err_in;
         s1_last_ff <= s1_last_in;
         s1_byte_ff <= req_ch.data_byte;
         s1_oob_ff  <= !({1'b0, req_ch.data_byte} < 9'(PALETTE_DEPTH));
      end
   end

   logic [RGB_W-1:0] rgb;
   logic [31:0]      word_in;

   always_comb begin
      rgb = s1_oob_ff ? '0 : rd_data_ff;
      if (s1_kind_ff == KIND_COLOUR) begin
         word_in = {OPAQUE_ALPHA, widen(rgb[23:16], expand_ff),
                    widen(rgb[15:8], expand_ff), widen(rgb[7:0], expand_ff)};
      end else begin
         word_in = {24'd0, s1_byte_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         out_word_ff <= word_in;
         out_kind_ff <= s1_kind_ff;
         out_err_ff  <= s1_err_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.out_word      = out_word_ff;
   assign rsp_ch.byte_kind     = out_kind_ff;
   assign rsp_ch.slab_error    = out_err_ff;
   assign rsp_ch.last_of_block = out_last_ff;

   `VSCX_ASSERT_NOW(a_err_ends_block, out_valid_ff && out_err_ff, out_last_ff,
                    "error word without last")
   `VSCX_ASSERT_NEXT(a_failed_silent, fire && failed_ff && !req_ch.first_of_block,
                     !s1_valid_ff, "word after failed slab")
   `VSCX_ASSERT_NOW(a_phase_has_bytes, phase_ff != PH_TOP, bytes_left_ff != '0,
                    "slab open with no bytes left")
   `VSCX_ASSERT_NEXT(a_skid_holds, s1_valid_ff && out_valid_ff && !rsp_ch.ready,
                     s1_valid_ff && $stable(s1_kind_ff), "stalled word lost")

endmodule

>>> bench/voxel_slab_color_expander_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the voxel slab color expander: directed and random slab blocks
module voxel_slab_color_expander_tb;
   import vscx_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int STALL_CYCLES = 300;
   localparam int RANDOM_ITEMS = 1000;
   localparam int PRINT_CAP    = 40;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
      logic       first;
      logic [7:0] idx;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } slab_item_type;

   typedef struct packed {
      logic [31:0]   word;
      byte_kind_type kind;
      logic          err;
      logic          last;
   } slab_word_type;

   typedef struct packed {
      logic [19:0]    left;
      slab_phase_type phase;
      logic [7:0]     colours;
      logic           failed;
   } slab_track_type;

   logic clock = 1'b0;
   logic reset;

   vscx_req_if req_if ();
   vscx_rsp_if rsp_if ();
   vscx_csr_if csr_if ();

   voxel_slab_color_expander dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   slab_item_type  pending_items[$];
   slab_word_type  expected_words[$];
   logic [23:0]    palette [256];
   bit             pal_written [256];
   int             written_list[$];
   int             slab_lens[$];
   logic [7:0]     block_plan[$];
   slab_track_type slab_state;
   slab_track_type plan_state;
   logic [19:0]    cfg_block_bytes = '0;
   logic           cfg_six_bit = 1'b1;
   int             send_idle_pct = 14;
   int             recv_idle_pct = 69;
   bit             stall_arm = 1'b0;
   bit             stall_done = 1'b0;
   int             stall_count = 0;
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             items_sent = 0;
   bit             start_block = 1'b0;
   bit             mix_pal = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] widen_component(input logic [7:0] c);
      logic [7:0] six;
      six = c & 8'h3f;
      return cfg_six_bit ? (((six << 2) | (six >> 4)) & 8'hff) : c;
   endfunction

   task automatic advance_slab(inout slab_track_type s, input logic first, input logic [7:0] b,
                               output logic emit, output byte_kind_type kind,
                               output logic err, output logic last);
      emit = 1'b0;
      kind = KIND_TOP;
      err  = 1'b0;
      last = 1'b0;
      if (first) begin
         s.left    = cfg_block_bytes;
         s.phase   = PH_TOP;
         s.colours = '0;
         s.failed  = 1'b0;
      end
      if (!s.failed && s.left != 0) begin
         if (s.phase == PH_TOP && s.left < 3) begin
            s.left = s.left - 1'b1;
         end else begin
            emit = 1'b1;
            case (s.phase)
               PH_TOP: begin
                  kind    = KIND_TOP;
                  s.phase = PH_LENGTH;
               end
               PH_LENGTH: begin
                  kind = KIND_LENGTH;
                  if (int'(b) + 2 > int'(s.left)) begin
                     err       = 1'b1;
                     last      = 1'b1;
                     s.failed  = 1'b1;
                     s.phase   = PH_TOP;
                     s.colours = '0;
                  end else begin
                     s.colours = b;
                     s.phase   = PH_FACE;
                  end
               end
               PH_FACE: begin
                  kind = KIND_FACE;
                  if (s.colours == 0) begin
                     s.phase = PH_TOP;
                     last    = (s.left <= 3);
                  end else begin
                     s.phase = PH_COLOUR;
                  end
               end
               default: begin
                  kind      = KIND_COLOUR;
                  s.colours = s.colours - 1'b1;
                  if (s.colours == 0) begin
                     s.phase = PH_TOP;
                     last    = (s.left <= 3);
                  end
               end
            endcase
            s.left = s.left - 1'b1;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t: %s got %h expected %h", $time, what, got, want);
   endtask

   task automatic push_pal(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] bl, input logic first);
      slab_item_type item;
      item = '{op: OP_PAL_WRITE, data: 8'($urandom), first: first, idx: idx,
               red: r, green: g, blue: bl};
      pending_items.push_back(item);
      if (!pal_written[idx]) begin
         pal_written[idx] = 1'b1;
         written_list.push_back(int'(idx));
      end
      items_sent++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      slab_item_type item;
      logic          emit, err, last;
      byte_kind_type kind;
      if (mix_pal && $urandom_range(0, 11) == 0)
         push_pal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      // a colour lookup may only touch entries already loaded
      if (!start_block && !plan_state.failed && plan_state.left != 0 &&
          plan_state.phase == PH_COLOUR && !pal_written[b])
         b = 8'(written_list[$urandom_range(0, written_list.size() - 1)]);
      advance_slab(plan_state, start_block, b, emit, kind, err, last);
      item = '{op: OP_SLAB_BYTE, data: b, first: start_block, idx: 8'($urandom),
               red: 8'($urandom), green: 8'($urandom), blue: 8'($urandom)};
      pending_items.push_back(item);
      start_block = 1'b0;
      items_sent++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_if.valid || expected_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [19:0] value);
      csr_if.index <= idx;
      csr_if.wdata <= value;
      csr_if.valid <= 1'b1;
      do @(posedge clock);
      while (!csr_if.ready);
      if (idx == CSR_BLOCK_BYTES)
         cfg_block_bytes = value;
      else
         cfg_six_bit = value[0];
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 88)
         return $urandom_range(0, 6);
      else if (r < 98)
         return $urandom_range(7, 40);
      return $urandom_range(200, 255);
   endfunction

   task automatic build_plan(input int trailing, output int total);
      block_plan.delete();
      foreach (slab_lens[i]) begin
         block_plan.push_back(8'($urandom));
         block_plan.push_back(8'(slab_lens[i]));
         block_plan.push_back(8'($urandom));
         repeat (slab_lens[i]) block_plan.push_back(8'($urandom));
      end
      repeat (trailing) block_plan.push_back(8'($urandom));
      total = block_plan.size();
   endtask

   task automatic send_plan(input int count);
      start_block = 1'b1;
      for (int i = 0; i < count && i < block_plan.size(); i++)
         push_byte(block_plan[i]);
   endtask

   task automatic run_random_block();
      int pattern, total, extra, bad_len;
      pattern = $urandom_range(0, 99);
      slab_lens.delete();
      if (pattern < 82) begin
         repeat ((pattern < 70) ? $urandom_range(1, 4) : $urandom_range(0, 2))
            slab_lens.push_back(pick_len());
         if (pattern < 70 && !stall_arm && items_sent > 150)
            slab_lens[0] = 255;
         build_plan((pattern < 70) ? $urandom_range(0, 2) : 0, total);
         if (pattern < 70) begin
            write_register(CSR_BLOCK_BYTES, 20'(total));
            if (slab_lens[0] == 255 && !stall_arm)
               stall_arm = 1'b1;
            repeat (($urandom_range(0, 4) == 0) ? 2 : 1) send_plan(total);
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
         end else begin
            // overlong slab after a well-formed prefix, then bytes that must be ignored
            extra   = $urandom_range(0, 5);
            bad_len = $urandom_range(extra + 1, 255);
            block_plan.push_back(8'($urandom));
            block_plan.push_back(8'(bad_len));
            repeat ($urandom_range(1, 6)) block_plan.push_back(8'($urandom));
            write_register(CSR_BLOCK_BYTES, 20'(total + 3 + extra));
            send_plan(block_plan.size());
         end
      end else if (pattern < 92) begin
         repeat ($urandom_range(1, 4)) slab_lens.push_back(pick_len());
         build_plan($urandom_range(0, 2), total);
         write_register(CSR_BLOCK_BYTES, 20'(total));
         send_plan($urandom_range(1, total - 1));
         send_plan(total);
      end else begin
         write_register(CSR_BLOCK_BYTES, 20'($urandom_range(0, 12)));
         start_block = 1'b1;
         repeat ($urandom_range(1, 15)) push_byte(8'($urandom));
      end
   endtask

   always @(posedge clock) begin : drive_req
      slab_item_type item;
      slab_word_type w;
      logic          emit, err, last;
      byte_kind_type kind;
      logic [23:0]   e;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (req_if.op == OP_PAL_WRITE) begin
               palette[req_if.pal_index] = {req_if.pal_red, req_if.pal_green, req_if.pal_blue};
            end else begin
               advance_slab(slab_state, req_if.first_of_block, req_if.data_byte,
                            emit, kind, err, last);
               if (emit) begin
                  e = palette[req_if.data_byte];
                  w.word = (kind == KIND_COLOUR) ?
                           {OPAQUE_ALPHA, widen_component(e[23:16]),
                            widen_component(e[15:8]), widen_component(e[7:0])} :
                           {24'h0, req_if.data_byte};
                  w.kind = kind;
                  w.err  = err;
                  w.last = last;
                  expected_words.push_back(w);
               end
            end
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               item = pending_items.pop_front();
               req_if.valid          <= 1'b1;
               req_if.op             <= item.op;
               req_if.data_byte      <= item.data;
               req_if.first_of_block <= item.first;
               req_if.pal_index      <= item.idx;
               req_if.pal_red        <= item.red;
               req_if.pal_green      <= item.green;
               req_if.pal_blue       <= item.blue;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      slab_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_if.out_word, 32'h0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_if.out_word !== want.word)
                  report_mismatch("out_word", rsp_if.out_word, want.word);
               if (rsp_if.byte_kind !== want.kind)
                  report_mismatch("byte_kind", 32'(rsp_if.byte_kind), 32'(want.kind));
               if (rsp_if.slab_error !== want.err)
                  report_mismatch("slab_error", 32'(rsp_if.slab_error), 32'(want.err));
               if (rsp_if.last_of_block !== want.last)
                  report_mismatch("last_of_block", 32'(rsp_if.last_of_block), 32'(want.last));
            end
         end
         if (stall_arm && !stall_done) begin
            stall_count  <= STALL_CYCLES;
            stall_done   <= 1'b1;
            rsp_if.ready <= 1'b0;
         end else if (stall_count != 0) begin
            stall_count  <= stall_count - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("voxel_slab_color_expander: mismatch");
         $finish;
      end
   end

   initial begin
      int rand_start, part;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.op             = OP_SLAB_BYTE;
      req_if.data_byte      = '0;
      req_if.first_of_block = 1'b0;
      req_if.pal_index      = '0;
      req_if.pal_red        = '0;
      req_if.pal_green      = '0;
      req_if.pal_blue       = '0;
      rsp_if.ready          = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.index          = CSR_BLOCK_BYTES;
      csr_if.wdata          = '0;
      slab_state            = '{left: '0, phase: PH_TOP, colours: '0, failed: 1'b0};
      plan_state            = slab_state;
      foreach (pal_written[i]) pal_written[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_register(CSR_EXPAND_SIX_BIT, 20'd1);
      write_register(CSR_BLOCK_BYTES, 20'd12);
      push_pal(8'h00, 8'hff, 8'hff, 8'hff, 1'b0);
      push_pal(8'hff, 8'h00, 8'h00, 8'h00, 1'b1);
      push_pal(8'h55, 8'h3f, 8'h40, 8'hc0, 1'b0);
      push_pal(8'haa, 8'h80, 8'h7f, 8'h01, 1'b1);
      start_block = 1'b1;
      push_byte(8'hff); push_byte(8'h04); push_byte(8'h00);
      push_byte(8'h00); push_byte(8'hff); push_byte(8'h55); push_byte(8'haa);
      push_byte(8'h00); push_byte(8'h00); push_byte(8'hff);
      push_byte(8'h12); push_byte(8'h34); push_byte(8'h56);
      wait_idle();
      write_register(CSR_EXPAND_SIX_BIT, 20'd0);
      write_register(CSR_BLOCK_BYTES, 20'd4);
      start_block = 1'b1;
      push_byte(8'h01); push_byte(8'h01); push_byte(8'h02); push_byte(8'haa);
      wait_idle();
      write_register(CSR_BLOCK_BYTES, 20'd3);
      start_block = 1'b1;
      push_byte(8'h80); push_byte(8'h01); push_byte(8'h7f);
      wait_idle();
      write_register(CSR_BLOCK_BYTES, 20'd0);
      start_block = 1'b1;
      push_byte(8'hff);
      wait_idle();
      write_register(CSR_BLOCK_BYTES, 20'd2);
      start_block = 1'b1;
      push_byte(8'h0f); push_byte(8'hf0);
      wait_idle();
      write_register(CSR_BLOCK_BYTES, 20'hfffff);
      start_block = 1'b1;
      push_byte(8'hc3); push_byte(8'h00); push_byte(8'h3c);
      wait_idle();

      mix_pal    = 1'b1;
      rand_start = items_sent;
      while (items_sent - rand_start < RANDOM_ITEMS) begin
         part = (items_sent - rand_start) * 3 / RANDOM_ITEMS;
         send_idle_pct = (part == 0) ? 14 : (part == 1) ? 69 : 0;
         recv_idle_pct = (part == 0) ? 69 : (part == 1) ? 14 : 0;
         if ($urandom_range(0, 3) == 0)
            write_register(CSR_EXPAND_SIX_BIT, 20'($urandom_range(0, 1)));
         run_random_block();
         wait_idle();
      end

      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("voxel_slab_color_expander: match");
      end else begin
         $display("voxel_slab_color_expander: mismatch");
      end
      $finish;
   end

endmodule
